// ===== design/ppa_pkg.sv =====
// shared types and constants for the packed pixel access block
package ppa_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MAX_WIDTH = 2048;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int PIX_AW    = 26;

    typedef enum logic [2:0] {
        CMD_RD_BYTE   = 3'd0,
        CMD_WR_BYTE   = 3'd1,
        CMD_GET_INDEX = 3'd2,
        CMD_SET_INDEX = 3'd3,
        CMD_GET_ALPHA = 3'd4,
        CMD_SET_ALPHA = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_MOD
    } state_t;

    localparam logic REG_PIXEL_FORMAT = 1'b0;
    localparam logic REG_IMAGE_WIDTH  = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [15:0] byte_addr;
        logic [7:0]  value;
        logic [31:0] fallback_color;
    } item_t;

    typedef struct packed {
        logic [PIX_AW-1:0] addr;
        logic [2:0]        shift;
        logic              err;
    } addr_info_t;

endpackage

// ===== design/ppa_ram.sv =====
// generic single-port-pair ram with registered read
module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/ppa_addr_gen.sv =====
// byte address, bit shift and range check of one access
module ppa_addr_gen
    import ppa_pkg::*;
(
    input  item_t      item,
    input  logic [2:0] pixel_format,
    input  logic [11:0] image_width,
    output addr_info_t info
);

    logic [1:0]        lg;
    logic [11:0]       w_sat;
    logic [14:0]       wbits;
    logic [15:0]       wround;
    logic [12:0]       stride;
    logic [23:0]       prod;
    logic [10:0]       xbyte;
    logic [10:0]       base;
    logic [2:0]        shift;
    logic [PIX_AW-1:0] pix;
    logic [PIX_AW-1:0] addr;
    logic              is_raw;

    assign lg     = pixel_format[1:0];
    assign w_sat  = (PIX_AW'(image_width) > PIX_AW'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : image_width;
    assign wbits  = 15'(w_sat) << lg;
    assign wround = 16'(wbits) + 16'd7;
    assign stride = wround[15:3];
    assign prod   = 24'(stride) * 24'(item.pos_y);

    always_comb
    begin
        case (lg)
            2'd0:
            begin
                xbyte = 11'(item.pos_x >> 3);
                shift = 3'd7 - item.pos_x[2:0];
                base  = 11'd8;
            end
            2'd1:
            begin
                xbyte = 11'(item.pos_x >> 2);
                shift = 3'd6 - {item.pos_x[1:0], 1'b0};
                base  = 11'd16;
            end
            2'd2:
            begin
                xbyte = 11'(item.pos_x >> 1);
                shift = item.pos_x[0] ? 3'd0 : 3'd4;
                base  = 11'd64;
            end
            default:
            begin
                xbyte = item.pos_x;
                shift = 3'd0;
                base  = 11'd1024;
            end
        endcase
    end

    assign pix = (pixel_format[2] ? PIX_AW'(base) : '0) + PIX_AW'(prod) + PIX_AW'(xbyte);

    assign is_raw = (item.command == CMD_RD_BYTE) || (item.command == CMD_WR_BYTE);
    assign addr   = is_raw ? PIX_AW'(item.byte_addr) : pix;

    assign info.addr  = addr;
    assign info.shift = shift;
    assign info.err   = (addr >= PIX_AW'(MEM_BYTES));

endmodule

// ===== design/ppa_rmw.sv =====
// sub-byte field merge and extraction with alpha expansion
module ppa_rmw
    import ppa_pkg::*;
(
    input  logic [1:0] lg,
    input  logic       want_index,
    input  logic [2:0] shift,
    input  logic [7:0] rdata,
    input  logic [7:0] value,
    output logic [7:0] merged,
    output logic [7:0] get_val
);

    logic [7:0] mask;
    logic [7:0] nv;
    logic [7:0] field;
    logic [7:0] alpha;

    always_comb
    begin
        case (lg)
            2'd0:
            begin
                mask = 8'h01;
                nv   = want_index ? (value & 8'h01) : 8'(value[7]);
            end
            2'd1:
            begin
                mask = 8'h03;
                nv   = want_index ? (value & 8'h03) : 8'(value[7:6]);
            end
            2'd2:
            begin
                mask = 8'h0F;
                nv   = want_index ? (value & 8'h0F) : 8'(value[7:4]);
            end
            default:
            begin
                mask = 8'hFF;
                nv   = value;
            end
        endcase
    end

    assign merged = (rdata & ~(mask << shift)) | ((nv & mask) << shift);
    assign field  = (rdata >> shift) & mask;

    // alpha expansion: 1 bit inverted, 2 bit times 85, 4 bit times 17
    always_comb
    begin
        case (lg)
            2'd0:    alpha = field[0] ? 8'd0 : 8'd255;
            2'd1:    alpha = {4{field[1:0]}};
            2'd2:    alpha = {2{field[3:0]}};
            default: alpha = field;
        endcase
    end

    assign get_val = want_index ? field : alpha;

endmodule

// ===== design/packed_pixel_access.sv =====
// sequence: the input beat is registered, the ram is read in the address state, and
// the write-back and result beat follow in the modify state; a new item is taken only
// as the current result is loaded, and a full output register not taken stalls the block
// reset: asynchronous active low, clears the sequencer and output valid, sets
// pixel_format to 3 and image_width to 1; image memory is not cleared
module packed_pixel_access
    import ppa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // pos_x, pos_y, byte_addr, value, fallback_color, pad
    input  logic [2:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_data
    output logic        m_axis_tuser,   // addr_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    state_t      state_reg;
    state_t      state_next;
    item_t       item_reg;
    item_t       item_in;
    addr_info_t  cur_info;
    addr_info_t  info_reg;
    logic [2:0]  fmt_reg;
    logic [11:0] width_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_err_reg;
    logic        out_free;
    logic        in_accept;
    logic        ram_re;
    logic        load_out;
    logic [7:0]  rdata;
    logic [7:0]  merged;
    logic [7:0]  get_val;
    logic        want_index;
    logic        is_set;
    logic        wr_req;
    logic [7:0]  wr_data;
    logic [31:0] res_data;
    logic        res_err;

    assign item_in.command        = s_axis_tuser;
    assign item_in.pos_x          = s_axis_tdata[10:0];
    assign item_in.pos_y          = s_axis_tdata[21:11];
    assign item_in.byte_addr      = s_axis_tdata[37:22];
    assign item_in.value          = s_axis_tdata[45:38];
    assign item_in.fallback_color = s_axis_tdata[77:46];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= 3'd3;
            width_reg <= 12'd1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_PIXEL_FORMAT)
            begin
                fmt_reg <= cfg_data[2:0];
            end
            else
            begin
                width_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = s_axis_tvalid ? ST_ADDR : ST_IDLE;
            ST_ADDR: state_next = ST_MOD;
            ST_MOD:
            begin
                if (out_free)
                begin
                    state_next = s_axis_tvalid ? ST_ADDR : ST_IDLE;
                end
                else
                begin
                    state_next = ST_MOD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_re        = 1'b0;
                load_out      = 1'b0;
            end
            ST_ADDR:
            begin
                s_axis_tready = 1'b0;
                ram_re        = 1'b1;
                load_out      = 1'b0;
            end
            ST_MOD:
            begin
                s_axis_tready = out_free;
                ram_re        = 1'b0;
                load_out      = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
                ram_re        = 1'b0;
                load_out      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= item_in;
        end
        if (ram_re)
        begin
            info_reg <= cur_info;
        end
    end

    ppa_addr_gen u_addr_gen (
        .item         (item_reg),
        .pixel_format (fmt_reg),
        .image_width  (width_reg),
        .info         (cur_info)
    );

    ppa_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_req && load_out),
        .waddr (info_reg.addr[MEM_AW-1:0]),
        .wdata (wr_data),
        .re    (ram_re),
        .raddr (cur_info.addr[MEM_AW-1:0]),
        .rdata (rdata)
    );

    assign want_index = (item_reg.command == CMD_GET_INDEX) ||
                        (item_reg.command == CMD_SET_INDEX);
    assign is_set     = (item_reg.command == CMD_SET_INDEX) ||
                        (item_reg.command == CMD_SET_ALPHA);

    ppa_rmw u_rmw (
        .lg         (fmt_reg[1:0]),
        .want_index (want_index),
        .shift      (info_reg.shift),
        .rdata      (rdata),
        .value      (item_reg.value),
        .merged     (merged),
        .get_val    (get_val)
    );

    always_comb
    begin
        res_data = '0;
        res_err  = 1'b0;
        wr_req   = 1'b0;
        wr_data  = item_reg.value;
        case (item_reg.command)
            CMD_RD_BYTE:
            begin
                res_err  = info_reg.err;
                res_data = info_reg.err ? 32'd0 : 32'(rdata);
            end
            CMD_WR_BYTE:
            begin
                res_err = info_reg.err;
                wr_req  = !info_reg.err;
            end
            CMD_GET_INDEX, CMD_SET_INDEX, CMD_GET_ALPHA, CMD_SET_ALPHA:
            begin
                if (want_index != fmt_reg[2])
                begin
                    if (item_reg.command == CMD_GET_INDEX)
                    begin
                        res_data = item_reg.fallback_color;
                    end
                    else if (item_reg.command == CMD_GET_ALPHA)
                    begin
                        res_data = 32'd255;
                    end
                end
                else if (info_reg.err)
                begin
                    res_err = 1'b1;
                end
                else if (is_set)
                begin
                    wr_req  = 1'b1;
                    wr_data = merged;
                end
                else
                begin
                    res_data = 32'(get_val);
                end
            end
            default:
            begin
                res_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= res_data;
            out_err_reg  <= res_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

// ===== design/ppa_checker.sv =====
// port-level checks for the packed pixel access block
module ppa_checker
    import ppa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // output beat held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // one item at a time: no beat taken in the address cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken during address cycle");

    // every taken beat has a result waiting after the address and modify states
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##3 m_axis_tvalid)
        else $error("result missing after input beat");

endmodule

bind packed_pixel_access ppa_checker u_ppa_checker (.*);
